/* design/mltev_pkg.sv */
// Shared constants and types for the multi-layer trigger event builder.
package mltev_pkg;

  localparam int LAYERS      = 6;
  localparam int QUEUE_DEPTH = 1024;

  // only layers below both LAYERS and the register width take part
  localparam int MAXL      = (LAYERS < 6) ? LAYERS : 6;
  localparam int LIDX_W    = (MAXL > 1) ? $clog2(MAXL) : 1;
  localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = MAXL * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // configuration port
  localparam int CFG_AW          = 3;
  localparam bit REG_ENABLED_IDX = 1'b0;
  localparam logic [5:0] ENABLED_RESET = 6'd63;

  // request codes
  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_BUILD = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_NOT_READY = 2'd0;
  localparam logic [1:0] STAT_PART      = 2'd1;
  localparam logic [1:0] STAT_DROP      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_WAIT,
    S_MATCH,
    S_EMIT
  } state_e;

endpackage

/* design/multi_layer_trigger_event_builder.sv */
// Event builder: per-layer frame queues in one shared memory, head matching and event emission.
// Push: accepted while idle, with busy low throughout; no result beat.
// Build: busy in S_CHECK, then a not-ready beat on the next cycle when a layer is empty or none is
// enabled; else S_READ per layer and S_WAIT read the heads and S_MATCH matches them, then a drop beat
// follows, or S_EMIT steps once per layer up to the highest enabled one, each beat registered behind it.
// Results cannot be stalled. Reset: queues empty, guards at depth minus one, all layers enabled.
module multi_layer_trigger_event_builder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type_i,
  input  logic [2:0]                   layer_i,
  input  logic [31:0]                  trigger_number_i,
  input  logic [31:0]                  frame_tag_i,
  output logic                         result_valid_o,
  output logic [1:0]                   status_o,
  output logic [2:0]                   out_layer_o,
  output logic [31:0]                  event_trigger_o,
  output logic [31:0]                  out_tag_o,
  output logic [5:0]                   matched_mask_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mltev_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mltev_pkg::*;

  // configuration
  logic [5:0]      enabled_q;
  logic [MAXL-1:0] en;

  // per-layer queue state
  logic [SLOT_W-1:0] wr_idx_q [MAXL];
  logic [SLOT_W-1:0] wr_idx_d [MAXL];
  logic [SLOT_W-1:0] rd_idx_q [MAXL];
  logic [SLOT_W-1:0] rd_idx_d [MAXL];
  logic [SLOT_W-1:0] guard_q  [MAXL];
  logic [SLOT_W-1:0] guard_d  [MAXL];
  logic [FILL_W-1:0] fill_q   [MAXL];
  logic [FILL_W-1:0] fill_d   [MAXL];

  // frame store
  logic [63:0]       mem [MEM_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [63:0]       rdata_q;

  // build control
  state_e            state_q, state_d;
  logic [LIDX_W-1:0] cnt_q, cnt_d;
  logic              rvld_q, rvld_d;
  logic [LIDX_W-1:0] rlyr_q;
  logic [31:0]       min_q, min_d;
  logic [MAXL-1:0]   matched_q, matched_d;
  logic [31:0]       head_trig_q [MAXL];
  logic [31:0]       head_tag_q  [MAXL];

  // result register
  logic        res_vld_q, res_vld_d;
  logic [1:0]  res_status_q, res_status_d;
  logic [2:0]  res_layer_q, res_layer_d;
  logic [31:0] res_trig_q, res_trig_d;
  logic [31:0] res_tag_q, res_tag_d;
  logic [5:0]  res_mask_q, res_mask_d;
  logic        res_last_q, res_last_d;

  logic              accept;
  logic              push_ok;
  logic [LIDX_W-1:0] push_l;
  logic [MAXL-1:0]   empty;
  logic              not_ready;
  logic              cfg_we;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LIDX_W-1:0] l,
                                                  input logic [SLOT_W-1:0] s);
    return ADDR_W'(l) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(s);
  endfunction

  assign en     = enabled_q[MAXL-1:0];
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign push_l = layer_i[LIDX_W-1:0];

  always_comb begin
    for (int l = 0; l < MAXL; l++) begin
      empty[l] = (fill_q[l] == '0);
    end
  end
  assign not_ready = (en == '0) || ((en & empty) != '0);

  // a push is dropped for a bad or disabled layer, a write index at the guard, or a full queue
  always_comb begin
    push_ok = 1'b0;
    if (accept && req_type_i == REQ_PUSH && layer_i < 3'(MAXL)) begin
      if (en[push_l] && wr_idx_q[push_l] != guard_q[push_l] &&
          fill_q[push_l] < FILL_W'(QUEUE_DEPTH)) begin
        push_ok = 1'b1;
      end
    end
  end

  assign mem_we    = push_ok;
  assign mem_waddr = slot_addr(push_l, wr_idx_q[push_l]);
  assign mem_raddr = slot_addr(cnt_q, rd_idx_q[cnt_q]);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= {trigger_number_i, frame_tag_i};
    end
    rdata_q <= mem[mem_raddr];
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ENABLED_IDX);
  assign prdata = (paddr[2] == REG_ENABLED_IDX) ? {26'd0, enabled_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= ENABLED_RESET;
    end else if (cfg_we) begin
      enabled_q <= pwdata[5:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && req_type_i == REQ_BUILD) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = not_ready ? S_IDLE : S_READ;
      end
      S_READ: begin
        if (cnt_q == LIDX_W'(MAXL - 1)) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_MATCH;
      end
      S_MATCH: begin
        state_d = (matched_d != en) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (res_last_d || cnt_q == LIDX_W'(MAXL - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic no_bad;
    logic hi_any;
    no_bad       = 1'b1;
    hi_any       = 1'b0;
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    guard_d      = guard_q;
    fill_d       = fill_q;
    cnt_d        = cnt_q;
    rvld_d       = 1'b0;
    min_d        = min_q;
    matched_d    = matched_q;
    res_vld_d    = 1'b0;
    res_status_d = STAT_NOT_READY;
    res_layer_d  = '0;
    res_trig_d   = '0;
    res_tag_d    = '0;
    res_mask_d   = '0;
    res_last_d   = 1'b0;

    // head beat returning from the memory
    if (rvld_q && rdata_q[63:32] < min_q) begin
      min_d = rdata_q[63:32];
    end

    case (state_q)
      S_IDLE: begin
        if (push_ok) begin
          wr_idx_d[push_l] = next_slot(wr_idx_q[push_l]);
          fill_d[push_l]   = fill_q[push_l] + 1'b1;
        end
        cnt_d = '0;
      end
      S_CHECK: begin
        // guards of enabled layers ahead of the first empty layer are still moved to their read index
        for (int l = 0; l < MAXL; l++) begin
          if (en[l] && empty[l]) begin
            no_bad = 1'b0;
          end
          if (en[l] && no_bad) begin
            guard_d[l] = rd_idx_q[l];
          end
        end
        min_d = '1;
        cnt_d = '0;
        if (not_ready) begin
          res_vld_d  = 1'b1;
          res_last_d = 1'b1;
        end
      end
      S_READ: begin
        rvld_d = en[cnt_q];
        if (cnt_q != LIDX_W'(MAXL - 1)) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_WAIT: begin
        cnt_d = '0;
      end
      S_MATCH: begin
        for (int l = 0; l < MAXL; l++) begin
          matched_d[l] = en[l] && (head_trig_q[l] == min_q);
          if (matched_d[l]) begin
            rd_idx_d[l] = next_slot(rd_idx_q[l]);
            fill_d[l]   = fill_q[l] - 1'b1;
          end
        end
        cnt_d = '0;
        if (matched_d != en) begin
          res_vld_d    = 1'b1;
          res_status_d = STAT_DROP;
          res_trig_d   = min_q;
          res_mask_d   = 6'(matched_d);
          res_last_d   = 1'b1;
        end
      end
      S_EMIT: begin
        for (int l = 0; l < MAXL; l++) begin
          if (en[l] && LIDX_W'(l) > cnt_q) begin
            hi_any = 1'b1;
          end
        end
        if (en[cnt_q]) begin
          res_vld_d    = 1'b1;
          res_status_d = STAT_PART;
          res_layer_d  = 3'(cnt_q);
          res_trig_d   = min_q;
          res_tag_d    = head_tag_q[cnt_q];
          res_mask_d   = 6'(matched_q);
          res_last_d   = !hi_any;
        end
        if (cnt_q != LIDX_W'(MAXL - 1)) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rvld_q    <= 1'b0;
      res_vld_q <= 1'b0;
      matched_q <= '0;
      min_q     <= '1;
      for (int l = 0; l < MAXL; l++) begin
        wr_idx_q[l] <= '0;
        rd_idx_q[l] <= '0;
        fill_q[l]   <= '0;
        guard_q[l]  <= SLOT_W'(QUEUE_DEPTH - 1);
      end
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rvld_q    <= rvld_d;
      res_vld_q <= res_vld_d;
      matched_q <= matched_d;
      min_q     <= min_d;
      wr_idx_q  <= wr_idx_d;
      rd_idx_q  <= rd_idx_d;
      fill_q    <= fill_d;
      guard_q   <= guard_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rlyr_q <= cnt_q;
    if (rvld_q) begin
      head_trig_q[rlyr_q] <= rdata_q[63:32];
      head_tag_q[rlyr_q]  <= rdata_q[31:0];
    end
    res_status_q <= res_status_d;
    res_layer_q  <= res_layer_d;
    res_trig_q   <= res_trig_d;
    res_tag_q    <= res_tag_d;
    res_mask_q   <= res_mask_d;
    res_last_q   <= res_last_d;
  end

  assign result_valid_o  = res_vld_q;
  assign status_o        = res_status_q;
  assign out_layer_o     = res_layer_q;
  assign event_trigger_o = res_trig_q;
  assign out_tag_o       = res_tag_q;
  assign matched_mask_o  = res_mask_q;
  assign last_o          = res_last_q;

endmodule
